>>> rtl/dfq_pkg.sv
`default_nettype none
package dfq_pkg;

  localparam int ITEM_W = 8;
  localparam int CNT_W  = 9;

  typedef enum logic [0:0] {
    FN_PUSH = 1'b0,
    FN_POP  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage
`default_nettype wire

>>> rtl/dfq_if.sv
`default_nettype none
// Request channel: one push or pop per item
interface dfq_in_if;
  logic                        valid;
  logic                        ready;
  dfq_pkg::func_t              func;
  logic [dfq_pkg::ITEM_W-1:0]  item;

  modport source (output valid, func, item, input ready);
  modport sink   (input valid, func, item, output ready);
endinterface

// Result channel: one result item per request
interface dfq_out_if;
  logic                        valid;
  logic                        ready;
  logic [dfq_pkg::ITEM_W-1:0]  popped_item;
  dfq_pkg::status_t            status;
  logic [dfq_pkg::CNT_W-1:0]   occupancy;
  logic                        is_full;
  logic                        is_empty;

  modport source (output valid, popped_item, status, occupancy, is_full, is_empty,
                  input ready);
  modport sink   (input valid, popped_item, status, occupancy, is_full, is_empty,
                  output ready);
endinterface

// Capacity register write channel
interface dfq_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [dfq_pkg::CNT_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

>>> rtl/dedup_fifo_move_to_back.sv
`default_nettype none
// The link tables are read as a request is taken; the update and result are registered in S_EXEC
// once the output register is free. Requests are taken one at a time; re-pushing an item from the
// middle also goes through S_LINK, since each link table has one write port and needs two writes.
// Reset: after rst_n, a clearing pass writes every presence bit, during which no request
// is taken; capacity writes are taken at any time.
module dedup_fifo_move_to_back #(
  parameter int MAX_ITEMS = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dfq_in_if.sink    in_chan,
  dfq_out_if.source out_chan,
  dfq_cfg_if.sink   cfg_chan
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = dfq_pkg::CNT_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LINK
  } state_t;

  state_t                      state_r, state_nxt;
  logic [IW-1:0]               clr_cnt_r, clr_cnt_nxt;
  logic [CW-1:0]               capacity_r, capacity_nxt;
  logic [IW-1:0]               head_r, head_nxt;
  logic [IW-1:0]               tail_r, tail_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  dfq_pkg::func_t              op_func_r, op_func_nxt;
  logic [dfq_pkg::ITEM_W-1:0]  op_item_r, op_item_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [dfq_pkg::ITEM_W-1:0]  popped_r, popped_nxt;
  dfq_pkg::status_t            status_r, status_nxt;
  logic [CW-1:0]               occ_r, occ_nxt;
  logic                        full_r, full_nxt;
  logic                        empty_r, empty_nxt;

  // link table ports; the previous table carries the presence bit on top
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  logic          nxt_we;
  logic [IW-1:0] nxt_waddr;
  logic [IW-1:0] nxt_wdata;
  logic [IW-1:0] nxt_rdata;
  logic          prv_we;
  logic [IW-1:0] prv_waddr;
  logic [IW:0]   prv_wdata;
  logic [IW:0]   prv_rdata;

  logic          in_accept;
  logic          out_free;
  logic [CW-1:0] eff_cap;
  logic [IW-1:0] x_idx;
  logic          rd_present;
  logic [IW-1:0] rd_prev;

  dfq_ram #(.DEPTH(MAX_ITEMS), .WIDTH(IW)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (nxt_rdata)
  );

  dfq_ram #(.DEPTH(MAX_ITEMS), .WIDTH(IW + 1)) u_prev_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (prv_rdata)
  );

  // effective capacity is the smaller of the register and the table depth
  assign eff_cap = (32'(capacity_r) < MAX_ITEMS) ? capacity_r : CW'(MAX_ITEMS);

  assign in_accept  = in_chan.valid && (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_chan.ready;
  assign x_idx      = IW'(op_item_r);
  assign rd_present = prv_rdata[IW];
  assign rd_prev    = prv_rdata[IW-1:0];

  // lookup of the addressed entry when the request is taken
  assign mem_re    = in_accept;
  assign mem_raddr = (in_chan.func == dfq_pkg::FN_POP) ? head_r : IW'(in_chan.item);

  always_comb begin
    logic [IW-1:0] h1;
    logic [IW-1:0] t1;
    logic [CW-1:0] c1;
    logic          mid;

    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    capacity_nxt  = capacity_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    op_func_nxt   = op_func_r;
    op_item_nxt   = op_item_r;
    out_valid_nxt = out_valid_r;
    popped_nxt    = popped_r;
    status_nxt    = status_r;
    occ_nxt       = occ_r;
    full_nxt      = full_r;
    empty_nxt     = empty_r;
    nxt_we        = 1'b0;
    nxt_waddr     = tail_r;
    nxt_wdata     = x_idx;
    prv_we        = 1'b0;
    prv_waddr     = x_idx;
    prv_wdata     = {1'b1, tail_r};
    h1            = head_r;
    t1            = tail_r;
    c1            = count_r;
    mid           = 1'b0;

    if (cfg_chan.valid) begin
      capacity_nxt = cfg_chan.data;
    end

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // sweep presence bits to zero
      S_CLEAR: begin
        prv_we      = 1'b1;
        prv_waddr   = clr_cnt_r;
        prv_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + IW'(1);
        if (clr_cnt_r == IW'(MAX_ITEMS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          op_func_nxt = in_chan.func;
          op_item_nxt = in_chan.item;
          state_nxt   = S_EXEC;
        end
      end

      // link update and result, once the output register can take it
      S_EXEC: begin
        if (out_free) begin
          popped_nxt = '0;
          status_nxt = dfq_pkg::ST_OK;
          state_nxt  = S_IDLE;
          if (op_func_r == dfq_pkg::FN_PUSH) begin
            if ({1'b0, op_item_r} >= eff_cap) begin
              status_nxt = dfq_pkg::ST_RANGE;
            end else if (count_r >= eff_cap) begin
              status_nxt = dfq_pkg::ST_FULL;
            end else begin
              // unlink if already queued
              if (rd_present) begin
                c1 = count_r - CW'(1);
                if (x_idx == head_r && x_idx == tail_r) begin
                  h1 = '0;
                  t1 = '0;
                end else if (x_idx == head_r) begin
                  h1 = nxt_rdata;
                end else if (x_idx == tail_r) begin
                  t1 = rd_prev;
                end else begin
                  mid = 1'b1;
                end
              end
              if (mid) begin
                // bridge neighbors now, append at the tail next cycle
                nxt_we    = 1'b1;
                nxt_waddr = rd_prev;
                nxt_wdata = nxt_rdata;
                prv_we    = 1'b1;
                prv_waddr = nxt_rdata;
                prv_wdata = {1'b1, rd_prev};
                state_nxt = S_LINK;
              end else begin
                nxt_we    = (c1 != '0);
                nxt_waddr = t1;
                nxt_wdata = x_idx;
                prv_we    = 1'b1;
                prv_waddr = x_idx;
                prv_wdata = {1'b1, t1};
                head_nxt  = (c1 == '0) ? x_idx : h1;
                tail_nxt  = x_idx;
                count_nxt = c1 + CW'(1);
              end
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = dfq_pkg::ST_EMPTY;
            end else begin
              popped_nxt = dfq_pkg::ITEM_W'(head_r);
              prv_we     = 1'b1;
              prv_waddr  = head_r;
              prv_wdata  = {1'b0, rd_prev};
              count_nxt  = count_r - CW'(1);
              if (head_r == tail_r) begin
                head_nxt = '0;
                tail_nxt = '0;
              end else begin
                head_nxt = nxt_rdata;
              end
            end
          end
          out_valid_nxt = 1'b1;
          occ_nxt       = count_nxt;
          full_nxt      = (count_nxt >= eff_cap);
          empty_nxt     = (count_nxt == '0);
        end
      end

      // second half of a move from the middle: append at the tail
      S_LINK: begin
        nxt_we    = 1'b1;
        nxt_waddr = tail_r;
        nxt_wdata = x_idx;
        prv_we    = 1'b1;
        prv_waddr = x_idx;
        prv_wdata = {1'b1, tail_r};
        tail_nxt  = x_idx;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      capacity_r  <= CW'(256);
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      capacity_r  <= capacity_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_func_r <= op_func_nxt;
    op_item_r <= op_item_nxt;
    popped_r  <= popped_nxt;
    status_r  <= status_nxt;
    occ_r     <= occ_nxt;
    full_r    <= full_nxt;
    empty_r   <= empty_nxt;
  end

  assign in_chan.ready        = (state_r == S_IDLE);
  assign cfg_chan.ready       = 1'b1;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.popped_item = popped_r;
  assign out_chan.status      = status_r;
  assign out_chan.occupancy   = occ_r;
  assign out_chan.is_full     = full_r;
  assign out_chan.is_empty    = empty_r;

endmodule
`default_nettype wire

>>> rtl/dfq_ram.sv
`default_nettype none
// Simple dual-port RAM, one write and one registered read per cycle
module dfq_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> rtl/dfq_checker.sv
`default_nettype none
module dfq_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [dfq_pkg::ITEM_W-1:0] popped_item,
  input wire dfq_pkg::status_t           status,
  input wire logic [dfq_pkg::CNT_W-1:0]  occupancy,
  input wire logic                       is_full,
  input wire logic                       is_empty
);

  // one request at a time: no new item right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous one in progress");

  // a waiting result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(popped_item) &&
      $stable(status) && $stable(occupancy) && $stable(is_full) && $stable(is_empty)))
    else $error("result changed while stalled");

  // empty flag agrees with occupancy
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (is_empty == (occupancy == '0)))
    else $error("is_empty disagrees with occupancy");

  // refused pop reports nothing and an empty queue
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status == dfq_pkg::ST_EMPTY) |-> (popped_item == '0 && is_empty))
    else $error("refused pop with data or nonempty queue");

  // refused push for fullness comes with the full flag
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status == dfq_pkg::ST_FULL) |-> is_full)
    else $error("push refused full while not full");

endmodule

bind dedup_fifo_move_to_back dfq_checker u_dfq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .popped_item (out_chan.popped_item),
  .status      (out_chan.status),
  .occupancy   (out_chan.occupancy),
  .is_full     (out_chan.is_full),
  .is_empty    (out_chan.is_empty)
);
`default_nettype wire
